// ===== sv/sf3rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sf3rgb_pkg
// Shared types, register indexes and the per-channel smoothing function for
// the 3x3 RGB smoothing filter.
// ----------------------------------------------------------------------------
package sf3rgb_pkg;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int FW_W        = 11;
  localparam int ROW_W       = 16;
  localparam int COL_OUT_W   = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Red in the low byte, then green, then blue.
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [7:0][PIX_W-1:0] nbr_t;

  // center/2 + (sum of eight neighbors)/16 on each channel; never above 254.
  function automatic pix_t smooth_pix(pix_t center, nbr_t nb);
    pix_t res;
    logic [CHAN_W+2:0] sum;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      sum = '0;
      for (int i = 0; i < 8; i++) begin
        sum = sum + (CHAN_W+3)'(nb[i][CHAN_W*k +: CHAN_W]);
      end
      res[CHAN_W*k +: CHAN_W] = {1'b0, center[CHAN_W*k+1 +: CHAN_W-1]}
                              + {1'b0, sum[CHAN_W+2:4]};
    end
    return res;
  endfunction

endpackage

// ===== sv/smoothing_filter_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// smoothing_filter_3x3_rgb
// Weighted 3x3 smoothing of a raster-order RGB stream: interior pixels become
// center/2 + (sum of eight neighbors)/16 per channel, border pixels pass.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_stall  | in_red, in_green, in_blue
//  output  | out_valid / out_stall| out_column, out_row, out_red, out_green,
//          |                      | out_blue, run_last
//  config  | cfg_write            | cfg_index, cfg_data
//
//  An item passes the window stage (row store read, 3x3 sum) and then sits
//  in the result register until its results are taken, one result per
//  cycle while out_stall is low. Most items give one result, so one item
//  per cycle is sustained without output stalls; the last pixel of a row
//  below the top gives two and bottom-row pixels up to three, and input
//  stalls meanwhile. Synchronous reset clears the counters, window and
//  valid flags; row stores are not cleared. A stalled output holds its
//  result and backs up into the input stall.
module smoothing_filter_3x3_rgb #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // pixel input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [sf3rgb_pkg::CHAN_W-1:0]          in_red,
  input  logic [sf3rgb_pkg::CHAN_W-1:0]          in_green,
  input  logic [sf3rgb_pkg::CHAN_W-1:0]          in_blue,
  // result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sf3rgb_pkg::COL_OUT_W-1:0]       out_column,
  output logic [sf3rgb_pkg::ROW_W-1:0]           out_row,
  output logic [sf3rgb_pkg::CHAN_W-1:0]          out_red,
  output logic [sf3rgb_pkg::CHAN_W-1:0]          out_green,
  output logic [sf3rgb_pkg::CHAN_W-1:0]          out_blue,
  output logic                                   run_last,
  // configuration writes
  input  logic                                   cfg_write,
  input  logic [sf3rgb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sf3rgb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sf3rgb_pkg::*;

  localparam int CW = $clog2(MAX_LINE);

  // Configuration
  logic [FW_W-1:0]  frame_width;
  logic [ROW_W-1:0] frame_height;
  logic             cfg_restart;
  logic [CW:0]      width_eff;
  logic [ROW_W-1:0] height_eff;

  // Position of the next input pixel
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;

  // Window stage
  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  pix_t             s1_pix;
  pix_t             s1_older;
  pix_t             s1_newer;
  pix_t             win [6];
  pix_t             smooth_res;
  pix_t             left_res;
  nbr_t             nbrs;
  logic             emit_left;
  logic             emit_end;
  logic             emit_bottom;
  logic             interior;

  // Result register: up to three pending results of one item
  logic [2:0]       s2_mask;
  logic [2:0]       s2_mask_next;
  logic [2:0]       s2_lowest;
  logic [CW-1:0]    s2_col;
  logic [CW-1:0]    s2_col_left;
  logic [ROW_W-1:0] s2_row;
  logic [ROW_W-1:0] s2_row_up;
  pix_t             s2_pix [3];
  pix_t             out_pix;
  logic             s2_last;
  logic             s2_free;
  logic             out_take;
  logic             s1_adv;
  logic             in_take;

  // ---------------------------------------------------------------- config
  always_comb begin
    unique case (cfg_index)
      REG_FRAME_WIDTH:  cfg_restart = cfg_write;
      REG_FRAME_HEIGHT: cfg_restart = cfg_write;
      default:          cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= ROW_W'(480);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one; width above the row store acts as its depth.
  always_comb begin
    priority if (frame_width == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(frame_width) > 32'(MAX_LINE)) begin
      width_eff = (CW+1)'(MAX_LINE);
    end else begin
      width_eff = (CW+1)'(frame_width);
    end
    height_eff = (frame_height == '0) ? ROW_W'(1) : frame_height;
  end

  // ---------------------------------------------------------------- handshake
  assign out_take = out_valid && !out_stall;
  // Result register frees when empty or when its final result is taken.
  assign s2_last  = (s2_mask & (s2_mask - 3'd1)) == 3'd0;
  assign s2_free  = (s2_mask == 3'd0) || (out_take && s2_last);
  assign s1_adv   = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------- counters
  always_comb begin
    col_next = col_count + CW'(1);
    row_next = row_count;
    if (({1'b0, col_count} + (CW+1)'(1)) >= width_eff) begin
      col_next = '0;
      row_next = row_count + ROW_W'(1);
      if (({1'b0, row_count} + (ROW_W+1)'(1)) >= {1'b0, height_eff}) begin
        row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_take) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // ---------------------------------------------------------------- row stores
  sf3rgb_line_buf #(
    .DEPTH(MAX_LINE)
  ) u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_take),
    .rd_addr  (col_count),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col),
    .wr_older (s1_newer),
    .wr_newer (s1_pix),
    .rd_older (s1_older),
    .rd_newer (s1_newer)
  );

  // ---------------------------------------------------------------- window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col <= col_count;
      s1_row <= row_count;
      s1_pix <= {in_blue, in_green, in_red};
    end
  end

  // Columns c-1 (entries 0..2) and c-2 (entries 3..5), top to bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= s1_older;
      win[1] <= s1_newer;
      win[2] <= s1_pix;
    end
  end

  assign nbrs = {win[0], win[2], win[3], win[4], win[5], s1_older, s1_newer, s1_pix};
  assign smooth_res = smooth_pix(win[1], nbrs);

  always_comb begin
    interior    = (s1_col >= CW'(2)) && (s1_row >= ROW_W'(2));
    emit_left   = (s1_row != '0) && (s1_col != '0);
    emit_end    = (s1_row != '0) && ({1'b0, s1_col} == (width_eff - (CW+1)'(1)));
    emit_bottom = (s1_row == (height_eff - ROW_W'(1)));
    left_res    = interior ? smooth_res : win[1];
  end

  // ---------------------------------------------------------------- results
  assign s2_lowest = s2_mask & (~s2_mask + 3'd1);

  always_comb begin
    s2_mask_next = s2_mask;
    if (s1_adv) begin
      s2_mask_next = {emit_bottom, emit_end, emit_left};
    end else if (out_take) begin
      s2_mask_next = s2_mask & ~s2_lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_mask <= '0;
    end else begin
      s2_mask <= s2_mask_next;
    end
  end

  // Left neighbor result, row-end result from the row above, bottom row pass.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col      <= s1_col;
      s2_col_left <= s1_col - CW'(1);
      s2_row      <= s1_row;
      s2_row_up   <= s1_row - ROW_W'(1);
      s2_pix[0]   <= left_res;
      s2_pix[1]   <= s1_newer;
      s2_pix[2]   <= s1_pix;
    end
  end

  // Drive the lowest pending result.
  always_comb begin
    priority if (s2_mask[0]) begin
      out_column = COL_OUT_W'(s2_col_left);
      out_row    = s2_row_up;
      out_pix    = s2_pix[0];
    end else if (s2_mask[1]) begin
      out_column = COL_OUT_W'(s2_col);
      out_row    = s2_row_up;
      out_pix    = s2_pix[1];
    end else begin
      out_column = COL_OUT_W'(s2_col);
      out_row    = s2_row;
      out_pix    = s2_pix[2];
    end
  end

  assign out_valid = s2_mask != 3'd0;
  assign run_last  = s2_last;
  assign out_red   = out_pix[0 +: CHAN_W];
  assign out_green = out_pix[CHAN_W +: CHAN_W];
  assign out_blue  = out_pix[2*CHAN_W +: CHAN_W];

endmodule

// ===== sv/sf3rgb_line_buf.sv =====
// ----------------------------------------------------------------------------
// sf3rgb_line_buf
// Two row stores (row two above and row just above the input) with a
// registered read and write-to-read forwarding for back-to-back items
// that hit the same column.
// ----------------------------------------------------------------------------
module sf3rgb_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  sf3rgb_pkg::pix_t            wr_older,
  input  sf3rgb_pkg::pix_t            wr_newer,
  output sf3rgb_pkg::pix_t            rd_older,
  output sf3rgb_pkg::pix_t            rd_newer
);
  import sf3rgb_pkg::*;

  pix_t older_mem [DEPTH];
  pix_t newer_mem [DEPTH];
  pix_t older_q;
  pix_t newer_q;
  pix_t fwd_older;
  pix_t fwd_newer;
  logic fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
      newer_mem[wr_addr] <= wr_newer;
    end
    if (rd_en) begin
      older_q   <= older_mem[rd_addr];
      newer_q   <= newer_mem[rd_addr];
      fwd_older <= wr_older;
      fwd_newer <= wr_newer;
    end
  end

  // Read-first array: take the data being written in the read cycle instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_older = fwd_hit ? fwd_older : older_q;
  assign rd_newer = fwd_hit ? fwd_newer : newer_q;

endmodule

// ===== sv/sf3rgb_checker.sv =====
// ----------------------------------------------------------------------------
// sf3rgb_checker
// Port-level checks on the smoothing filter, bound to the top level.
// ----------------------------------------------------------------------------
module sf3rgb_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [sf3rgb_pkg::COL_OUT_W-1:0]       out_column,
  input logic [sf3rgb_pkg::ROW_W-1:0]           out_row,
  input logic [sf3rgb_pkg::CHAN_W-1:0]          out_red,
  input logic [sf3rgb_pkg::CHAN_W-1:0]          out_green,
  input logic [sf3rgb_pkg::CHAN_W-1:0]          out_blue,
  input logic                                   run_last
);

  // Nothing comes out in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // A run that is not finished continues in the next cycle.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !run_last) |=> out_valid)
    else $error("run ended without its last result");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_column) && $stable(out_row)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(run_last)))
    else $error("stalled result changed");

  // Input stalls only while an item taken earlier still waits in the window stage.
  a_stall_needs_work: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !$past(in_valid && !in_stall) && !$past(in_stall)) |-> 1'b0)
    else $error("input stalled with no item inside");

endmodule

bind smoothing_filter_3x3_rgb sf3rgb_checker u_sf3rgb_checker (.*);
